// File: hw/rtl/charlieplex_percent_display_scan_macros.svh
// Assertion macros used by the display scan sequencer RTL.
`ifndef CHARLIEPLEX_PERCENT_DISPLAY_SCAN_MACROS_SVH
`define CHARLIEPLEX_PERCENT_DISPLAY_SCAN_MACROS_SVH
`ifndef SYNTHESIS
`define CPDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpds assertion failed");
`define CPDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpds assertion failed");
`else
`define CPDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPDS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/cpds_pkg.sv
// Types, constants, microcode and lookup tables for the display scan.
package cpds_pkg;

    localparam int UPC_W = 3;

    typedef enum logic [2:0] {
        SRC_PCT,
        SRC_CHG,
        SRC_H0,
        SRC_H1,
        SRC_TENS,
        SRC_UNITS
    } src_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_CHG,
        COND_HUND,
        COND_TENS
    } cond_t;

    typedef struct packed {
        src_t             src;
        cond_t            cond;
        logic [UPC_W-1:0] fail_pc;
        logic             last;
    } uword_t;

    typedef struct packed {
        logic [2:0] hi;
        logic [2:0] lo;
    } pin_pair_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic load;
        logic emit;
        src_t src;
        logic last_step;
    } ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic chg;
        logic hund;
        logic tens_en;
        logic seg_final;
        logic slot_free;
    } stat_t;

    localparam logic [UPC_W-1:0] PC_PCT   = 3'd0;
    localparam logic [UPC_W-1:0] PC_CHG   = 3'd1;
    localparam logic [UPC_W-1:0] PC_HUND  = 3'd2;
    localparam logic [UPC_W-1:0] PC_HUND1 = 3'd3;
    localparam logic [UPC_W-1:0] PC_TENS  = 3'd4;
    localparam logic [UPC_W-1:0] PC_UNITS = 3'd5;

    localparam logic [7:0] PCT_SAT = 8'd100;
    localparam logic [7:0] RADIX   = 8'd10;
    // Multiply by RECIP and shift right by RECIP_SH divides by ten for values below 100.
    localparam logic [7:0] RECIP    = 8'd205;
    localparam int         RECIP_SH = 11;

    localparam pin_pair_t PINS_PCT = '{hi: 3'd1, lo: 3'd4};
    localparam pin_pair_t PINS_CHG = '{hi: 3'd2, lo: 3'd4};
    localparam pin_pair_t PINS_H0  = '{hi: 3'd2, lo: 3'd3};
    localparam pin_pair_t PINS_H1  = '{hi: 3'd1, lo: 3'd3};

    // The frame program. A step whose condition fails jumps to fail_pc.
    function automatic uword_t ucode_f(logic [UPC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_PCT:   w = '{src: SRC_PCT,   cond: COND_ALWAYS, fail_pc: PC_CHG,   last: 1'b0};
            PC_CHG:   w = '{src: SRC_CHG,   cond: COND_CHG,    fail_pc: PC_HUND,  last: 1'b0};
            PC_HUND:  w = '{src: SRC_H0,    cond: COND_HUND,   fail_pc: PC_TENS,  last: 1'b0};
            PC_HUND1: w = '{src: SRC_H1,    cond: COND_ALWAYS, fail_pc: PC_TENS,  last: 1'b0};
            PC_TENS:  w = '{src: SRC_TENS,  cond: COND_TENS,   fail_pc: PC_UNITS, last: 1'b0};
            PC_UNITS: w = '{src: SRC_UNITS, cond: COND_ALWAYS, fail_pc: PC_UNITS, last: 1'b1};
            default:  w = '{src: SRC_UNITS, cond: COND_ALWAYS, fail_pc: PC_UNITS, last: 1'b1};
        endcase
        return w;
    endfunction

    // Seven-segment patterns, bit 0 is segment A.
    function automatic logic [6:0] seg_mask_f(logic [3:0] d);
        logic [6:0] m;
        case (d)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h3F;
        endcase
        return m;
    endfunction

    function automatic pin_pair_t tens_pins_f(logic [2:0] s);
        pin_pair_t p;
        case (s)
            3'd0:    p = '{hi: 3'd1, lo: 3'd2};
            3'd1:    p = '{hi: 3'd2, lo: 3'd1};
            3'd2:    p = '{hi: 3'd3, lo: 3'd2};
            3'd3:    p = '{hi: 3'd3, lo: 3'd1};
            3'd4:    p = '{hi: 3'd4, lo: 3'd1};
            3'd5:    p = '{hi: 3'd4, lo: 3'd2};
            3'd6:    p = '{hi: 3'd4, lo: 3'd3};
            default: p = '{hi: 3'd1, lo: 3'd2};
        endcase
        return p;
    endfunction

    function automatic pin_pair_t units_pins_f(logic [2:0] s);
        pin_pair_t p;
        case (s)
            3'd0:    p = '{hi: 3'd0, lo: 3'd1};
            3'd1:    p = '{hi: 3'd1, lo: 3'd0};
            3'd2:    p = '{hi: 3'd0, lo: 3'd2};
            3'd3:    p = '{hi: 3'd2, lo: 3'd0};
            3'd4:    p = '{hi: 3'd0, lo: 3'd3};
            3'd5:    p = '{hi: 3'd3, lo: 3'd0};
            3'd6:    p = '{hi: 3'd4, lo: 3'd0};
            default: p = '{hi: 3'd0, lo: 3'd1};
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/cpds_if.sv
// Valid/ready channel interfaces for the input item and the drive-step beat.
interface cpds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] soc;
    logic       charging;

    modport source (output valid, output soc, output charging, input ready);
    modport sink (input valid, input soc, input charging, output ready);
endinterface

interface cpds_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] high_pin;
    logic [2:0] low_pin;
    logic       last_step;

    modport source (output valid, output high_pin, output low_pin, output last_step,
                    input ready);
    modport sink (input valid, input high_pin, input low_pin, input last_step,
                  output ready);
endinterface

// File: hw/rtl/cpds_dp.sv
// Datapath: digit split, segment picking, pin lookup and the output register.
module cpds_dp
    import cpds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        soc,
    input  logic              charging,
    input  ctl_t              ctl,
    output stat_t             stat,
    cpds_out_if.source        out_step
);

    logic       chg_reg;
    logic       hund_reg;
    logic       tens_en_reg;
    logic [3:0] tens_reg;
    logic [3:0] units_reg;
    logic [6:0] done_reg;
    logic [6:0] done_next;
    logic       out_valid_reg;
    pin_pair_t  out_pins_reg;
    logic       out_last_reg;

    logic        sat;
    logic [6:0]  v7;
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    logic [6:0]  rem7;

    logic        is_digit;
    logic [3:0]  digit;
    logic [6:0]  mask;
    logic [6:0]  remain;
    logic [6:0]  pick;
    logic [2:0]  seg_idx;
    pin_pair_t   pins;
    logic        slot_free;

    // Divide by ten via reciprocal multiply; only used for values below 100.
    assign sat  = (soc >= PCT_SAT);
    assign v7   = soc[6:0];
    assign prod = 15'(v7) * 15'(RECIP);
    assign q    = prod[RECIP_SH +: 4];
    assign q10  = {q, 3'b000} + {2'b00, q, 1'b0};
    assign rem7 = v7 - q10;

    assign is_digit = (ctl.src == SRC_TENS) || (ctl.src == SRC_UNITS);
    assign digit    = (ctl.src == SRC_TENS) ? tens_reg : units_reg;
    assign mask     = seg_mask_f(digit);
    assign remain   = mask & ~done_reg;
    assign pick     = remain & (~remain + 7'd1);

    always_comb
    begin
        seg_idx = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (pick[i])
            begin
                seg_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        case (ctl.src)
            SRC_PCT:   pins = PINS_PCT;
            SRC_CHG:   pins = PINS_CHG;
            SRC_H0:    pins = PINS_H0;
            SRC_H1:    pins = PINS_H1;
            SRC_TENS:  pins = tens_pins_f(seg_idx);
            SRC_UNITS: pins = units_pins_f(seg_idx);
            default:   pins = PINS_PCT;
        endcase
    end

    assign slot_free = !out_valid_reg || out_step.ready;

    always_comb
    begin
        done_next = done_reg;
        if (ctl.emit && is_digit)
        begin
            done_next = stat.seg_final ? 7'd0 : (done_reg | pick);
        end
    end

    assign stat.chg       = chg_reg;
    assign stat.hund      = hund_reg;
    assign stat.tens_en   = tens_en_reg;
    assign stat.seg_final = !is_digit || ((remain & ~pick) == 7'd0);
    assign stat.slot_free = slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_step.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            chg_reg     <= charging;
            hund_reg    <= sat;
            tens_en_reg <= (soc >= RADIX);
            tens_reg    <= sat ? 4'd0 : q;
            units_reg   <= sat ? 4'd0 : rem7[3:0];
        end
        if (ctl.emit)
        begin
            out_pins_reg <= pins;
            out_last_reg <= ctl.last_step;
        end
    end

    assign out_step.valid     = out_valid_reg;
    assign out_step.high_pin  = out_pins_reg.hi;
    assign out_step.low_pin   = out_pins_reg.lo;
    assign out_step.last_step = out_last_reg;

endmodule

// File: hw/rtl/cpds_useq.sv
// Microcoded sequencer: program counter, control store and conditional jumps.
`include "charlieplex_percent_display_scan_macros.svh"
module cpds_useq
    import cpds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  busy
);

    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uw;
    logic             cond_ok;

    assign uw = ucode_f(upc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_CHG:    cond_ok = stat.chg;
            COND_HUND:   cond_ok = stat.hund;
            COND_TENS:   cond_ok = stat.tens_en;
            default:     cond_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        ctl.load      = start;
        ctl.emit      = 1'b0;
        ctl.src       = uw.src;
        ctl.last_step = uw.last && stat.seg_final;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = PC_PCT;
        end
        else if (busy_reg && stat.slot_free)
        begin
            if (!cond_ok)
            begin
                upc_next = uw.fail_pc;
            end
            else
            begin
                ctl.emit = 1'b1;
                // A digit step repeats until its last lit segment goes out.
                if (stat.seg_final)
                begin
                    if (uw.last)
                    begin
                        busy_next = 1'b0;
                        upc_next  = PC_PCT;
                    end
                    else
                    begin
                        upc_next = upc_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= PC_PCT;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    assign busy = busy_reg;

    `CPDS_ASSERT_IMP(a_emit_busy, clk, rst_n, ctl.emit, busy_reg && stat.slot_free)
    `CPDS_ASSERT_IMP(a_pc_range, clk, rst_n, busy_reg, upc_reg <= PC_UNITS)
    `CPDS_ASSERT_NXT(a_start_pc, clk, rst_n, start, busy_reg && upc_reg == PC_PCT)
    `CPDS_ASSERT_NXT(a_end_idle, clk, rst_n, ctl.emit && ctl.last_step, !busy_reg)
    `CPDS_ASSERT_IMP(a_last_units, clk, rst_n, ctl.emit && ctl.last_step,
                     upc_reg == PC_UNITS)

endmodule

// File: hw/rtl/charlieplex_percent_display_scan.sv
// The input beat loads the digit registers and sets busy; the first drive step is then
// registered in the output register once it is free. A frame holds N lit steps (3 to 16);
// each skipped optional step (charge mark, hundreds, tens) costs the sequencer a jump.
// The step rate is set by the microcode sequencer, which emits at most one step per cycle.
// Output stalls hold the sequencer; the next input is taken while the last beat waits.
// Reset clears the sequencer, done mask and output valid; loaded values are not reset.
module charlieplex_percent_display_scan
    import cpds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cpds_in_if.sink    in_item,
    cpds_out_if.source out_step
);

    ctl_t  ctl;
    stat_t stat;
    logic  busy;
    logic  start;

    assign in_item.ready = !busy;
    assign start         = in_item.valid && !busy;

    cpds_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    cpds_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .soc      (in_item.soc),
        .charging (in_item.charging),
        .ctl      (ctl),
        .stat     (stat),
        .out_step (out_step)
    );

endmodule
